/* design/fwsm_pkg.sv */
// ----------------------------------------------------------------------------
// fwsm_pkg
// shared constants, codes and control types of the folded walk segment map
// ----------------------------------------------------------------------------
`default_nettype none

package fwsm_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int POS_WIDTH_DEF    = 32;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_MAP_POS  = 2'd2;
  localparam logic [1:0] CMD_MAP_BRK  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NO_COVER = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic accept;
    logic step;
    logic capture;
    logic finish;
  } fwsm_cmd_t;

  typedef struct packed {
    logic table_empty;
    logic search_last;
    logic search_miss;
  } fwsm_sts_t;

endpackage

`default_nettype wire

/* design/folded_walk_segment_map.sv */
// ----------------------------------------------------------------------------
// folded_walk_segment_map
// append-only walk segment table with fold check and binary-search mapping
// adds: result registered at the transfer edge, next one taken unless stalled
// lookups: s search steps, s at most floor(log2(n)) + 1 over n segments, one
//   table read per step, then a difference step and a mapping step;
//   a miss returns after its last step, an empty table at the transfer edge
// reset: control and segment count cleared, table memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module folded_walk_segment_map #(
  parameter int MAX_SEGMENTS = fwsm_pkg::MAX_SEGMENTS_DEF,
  parameter int POS_WIDTH    = fwsm_pkg::POS_WIDTH_DEF,
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_command,
  input  wire logic [POS_WIDTH-1:0] in_start_pos,
  input  wire logic [POS_WIDTH-1:0] in_origin_pos,
  input  wire logic [POS_WIDTH-1:0] in_run_len,
  input  wire logic                 in_direction,
  input  wire logic [POS_WIDTH-1:0] in_query_pos,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic [POS_WIDTH-1:0]      out_mapped_pos,
  output logic [POS_WIDTH-1:0]      out_walk_length,
  output logic [CNT_W-1:0]          out_segment_count
);

  fwsm_pkg::fwsm_cmd_t cmd;
  fwsm_pkg::fwsm_sts_t sts;

  fwsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_lookup (in_command[1]),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  fwsm_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .POS_WIDTH    (POS_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_command),
    .in_start_pos      (in_start_pos),
    .in_origin_pos     (in_origin_pos),
    .in_run_len        (in_run_len),
    .in_direction      (in_direction),
    .in_query_pos      (in_query_pos),
    .out_status        (out_status),
    .out_mapped_pos    (out_mapped_pos),
    .out_walk_length   (out_walk_length),
    .out_segment_count (out_segment_count)
  );

endmodule

`default_nettype wire

/* design/fwsm_ctrl.sv */
// ----------------------------------------------------------------------------
// fwsm_ctrl
// sequencer for the segment map: accept, search steps, mapping, output valid
// ----------------------------------------------------------------------------
`default_nettype none

module fwsm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_lookup,
  input  wire logic                out_stall,
  input  wire fwsm_pkg::fwsm_sts_t sts,
  output fwsm_pkg::fwsm_cmd_t      cmd,
  output logic                     in_stall,
  output logic                     out_valid
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DIFF   = 2'd2;
  localparam logic [1:0] S_MAP    = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       load;

  always_comb begin
    in_stall    = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
    accept      = in_valid && !in_stall;
    cmd.accept  = accept;
    cmd.step    = (state_r == S_SEARCH);
    cmd.capture = (state_r == S_DIFF);
    cmd.finish  = (state_r == S_MAP);
    load = (accept && (!in_lookup || sts.table_empty))
        || (cmd.step && sts.search_last && sts.search_miss)
        || cmd.finish;
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_lookup && !sts.table_empty) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.search_last) state_nxt = sts.search_miss ? S_IDLE : S_DIFF;
      end
      S_DIFF: begin
        state_nxt = S_MAP;
      end
      S_MAP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/fwsm_dp.sv */
// ----------------------------------------------------------------------------
// fwsm_dp
// segment table memory, append check, search registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fwsm_dp #(
  parameter int MAX_SEGMENTS = fwsm_pkg::MAX_SEGMENTS_DEF,
  parameter int POS_WIDTH    = fwsm_pkg::POS_WIDTH_DEF,
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1),
  localparam int IDX_W = $clog2(MAX_SEGMENTS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fwsm_pkg::fwsm_cmd_t  cmd,
  output fwsm_pkg::fwsm_sts_t       sts,
  input  wire logic [1:0]           in_command,
  input  wire logic [POS_WIDTH-1:0] in_start_pos,
  input  wire logic [POS_WIDTH-1:0] in_origin_pos,
  input  wire logic [POS_WIDTH-1:0] in_run_len,
  input  wire logic                 in_direction,
  input  wire logic [POS_WIDTH-1:0] in_query_pos,
  output logic [1:0]                out_status,
  output logic [POS_WIDTH-1:0]      out_mapped_pos,
  output logic [POS_WIDTH-1:0]      out_walk_length,
  output logic [CNT_W-1:0]          out_segment_count
);

  localparam int ENT_W = 3 * POS_WIDTH + 1;
  localparam logic [CNT_W-1:0]     CNT_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0]     CNT_ONE = CNT_W'(1);
  localparam logic [POS_WIDTH-1:0] POS_TWO = POS_WIDTH'(2);
  localparam logic [POS_WIDTH-1:0] POS_ZERO = '0;

  logic [ENT_W-1:0] mem [MAX_SEGMENTS];
  logic [ENT_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0]     used_r;
  logic [POS_WIDTH-1:0] walk_end_r;
  logic [POS_WIDTH-1:0] want_r;
  logic                 last_dir_r;

  logic [POS_WIDTH-1:0] query_r;
  logic                 brk_r;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [POS_WIDTH-1:0] diff_r, orig_r;
  logic                 dir_r;

  logic [1:0]           status_r;
  logic [POS_WIDTH-1:0] mapped_r, walk_r;
  logic [CNT_W-1:0]     count_r;

  logic [POS_WIDTH-1:0] rd_start, rd_origin;
  logic                 rd_dir;
  logic [CNT_W-1:0]     half, mid, lo_less;
  logic                 probe_le;

  logic                 is_add, full, fits, accept_seg;
  logic [POS_WIDTH-1:0] start_sel, new_end, new_want;
  logic [POS_WIDTH-1:0] mapped_calc;

  always_comb begin
    rd_start  = rd_q[POS_WIDTH-1:0];
    rd_origin = rd_q[2*POS_WIDTH-1:POS_WIDTH];
    rd_dir    = rd_q[ENT_W-1];

    half     = cnt_r >> 1;
    mid      = lo_r + half;
    probe_le = (rd_start <= query_r);
    lo_nxt   = probe_le ? (mid + CNT_ONE) : lo_r;
    cnt_nxt  = probe_le ? (cnt_r - half - CNT_ONE) : half;
    lo_less  = lo_nxt - CNT_ONE;

    sts.table_empty = (used_r == '0);
    sts.search_last = (cnt_nxt == '0);
    sts.search_miss = (lo_nxt == '0);

    is_add     = !in_command[1];
    start_sel  = (in_command == fwsm_pkg::CMD_APPEND) ? walk_end_r : in_start_pos;
    full       = (used_r == CNT_MAX);
    fits       = (used_r == '0)
              || ((start_sel == walk_end_r) && (in_direction != last_dir_r)
                  && (in_origin_pos == want_r));
    accept_seg = cmd.accept && is_add && !full && fits;
    new_end    = start_sel + in_run_len;
    new_want   = in_direction ? (in_origin_pos + in_run_len - POS_TWO)
                              : (in_origin_pos - in_run_len + POS_TWO);

    mapped_calc = dir_r ? (orig_r + diff_r)
                        : (orig_r - diff_r + POS_WIDTH'(brk_r));

    rd_addr = '0;
    if (cmd.accept) begin
      rd_addr = IDX_W'(used_r >> 1);
    end else if (cmd.step) begin
      rd_addr = sts.search_last ? lo_less[IDX_W-1:0]
                                : IDX_W'(lo_nxt + (cnt_nxt >> 1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept_seg) begin
      mem[used_r[IDX_W-1:0]] <= {in_direction, in_run_len, in_origin_pos, start_sel};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      walk_end_r <= '0;
    end else if (accept_seg) begin
      used_r     <= used_r + CNT_ONE;
      walk_end_r <= new_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_seg) begin
      want_r     <= new_want;
      last_dir_r <= in_direction;
    end
    if (cmd.accept) begin
      query_r <= in_query_pos;
      brk_r   <= in_command[0];
      lo_r    <= '0;
      cnt_r   <= used_r;
    end else if (cmd.step) begin
      lo_r  <= lo_nxt;
      cnt_r <= cnt_nxt;
    end
    if (cmd.capture) begin
      diff_r <= query_r - rd_start;
      orig_r <= rd_origin;
      dir_r  <= rd_dir;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.accept && is_add) begin
      status_r <= full ? fwsm_pkg::ST_FULL : (fits ? fwsm_pkg::ST_OK : fwsm_pkg::ST_REJECT);
      mapped_r <= POS_ZERO;
      walk_r   <= accept_seg ? new_end : walk_end_r;
      count_r  <= accept_seg ? (used_r + CNT_ONE) : used_r;
    end else if ((cmd.accept && sts.table_empty)
                 || (cmd.step && sts.search_last && sts.search_miss)) begin
      status_r <= fwsm_pkg::ST_NO_COVER;
      mapped_r <= POS_ZERO;
      walk_r   <= walk_end_r;
      count_r  <= used_r;
    end else if (cmd.finish) begin
      status_r <= fwsm_pkg::ST_OK;
      mapped_r <= mapped_calc;
      walk_r   <= walk_end_r;
      count_r  <= used_r;
    end else begin
      status_r <= status_r;
    end
  end

  assign out_status        = status_r;
  assign out_mapped_pos    = mapped_r;
  assign out_walk_length   = walk_r;
  assign out_segment_count = count_r;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// runs segment adds, appends and lookups through folded_walk_segment_map and
// checks every result against a transaction-level model of the segment table or,
// for typed rows, their given result; random idling on both channels, one long output hold
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG         = fwsm_pkg::MAX_SEGMENTS_DEF;
  localparam int CNT_W        = $clog2(NSEG + 1);
  localparam int RAND_ITEMS   = 900;
  localparam int PHASE_ITEMS  = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 5000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] start_pos;
    logic [31:0] origin_pos;
    logic [31:0] run_len;
    logic        direction;
    logic [31:0] query_pos;
  } seg_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      mapped_pos;
    logic [31:0]      walk_length;
    logic [CNT_W-1:0] segment_count;
  } seg_res_t;

  typedef struct packed {
    seg_req_t req;
    logic     typed;
    seg_res_t res;
  } vec_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_command = fwsm_pkg::CMD_MAP_POS;
  logic [31:0]      in_start_pos = '0;
  logic [31:0]      in_origin_pos = '0;
  logic [31:0]      in_run_len = '0;
  logic             in_direction = 1'b0;
  logic [31:0]      in_query_pos = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [31:0]      out_mapped_pos;
  logic [31:0]      out_walk_length;
  logic [CNT_W-1:0] out_segment_count;

  // segment table model
  logic [31:0] tbl_start  [NSEG];
  logic [31:0] tbl_origin [NSEG];
  logic [31:0] tbl_run    [NSEG];
  logic        tbl_dir    [NSEG];
  int unsigned tbl_used = 0;

  seg_res_t map_results_q[$];
  int       errors = 0;
  int       phase = 0;
  bit       hold_request = 1'b0;

  always #2 clk = ~clk;

  folded_walk_segment_map u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_start_pos      (in_start_pos),
    .in_origin_pos     (in_origin_pos),
    .in_run_len        (in_run_len),
    .in_direction      (in_direction),
    .in_query_pos      (in_query_pos),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_mapped_pos    (out_mapped_pos),
    .out_walk_length   (out_walk_length),
    .out_segment_count (out_segment_count)
  );

  function automatic int idle_pct(bit sender);
    case (phase)
      0: return sender ? 15 : 66;
      1: return sender ? 66 : 15;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] walk_end();
    if (tbl_used == 0) return '0;
    return tbl_start[tbl_used-1] + tbl_run[tbl_used-1];
  endfunction

  // origin that folds back next to the end of the newest segment
  function automatic logic [31:0] fold_origin();
    int unsigned last;
    last = tbl_used - 1;
    if (tbl_dir[last]) return tbl_origin[last] + tbl_run[last] - 32'd2;
    return tbl_origin[last] - tbl_run[last] + 32'd2;
  endfunction

  function automatic logic [1:0] append_segment(logic [31:0] s, logic [31:0] o,
                                                logic [31:0] n, logic d);
    if (tbl_used >= NSEG) return fwsm_pkg::ST_FULL;
    if (tbl_used != 0) begin
      if (s != walk_end() || d == tbl_dir[tbl_used-1] || o != fold_origin())
        return fwsm_pkg::ST_REJECT;
    end
    tbl_start[tbl_used]  = s;
    tbl_origin[tbl_used] = o;
    tbl_run[tbl_used]    = n;
    tbl_dir[tbl_used]    = d;
    tbl_used++;
    return fwsm_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] map_query(logic [31:0] q, logic brk,
                                           output logic [31:0] m);
    int unsigned lo, cnt, half, mid;
    logic [31:0] diff;
    lo  = 0;
    cnt = tbl_used;
    m   = '0;
    while (cnt > 0) begin
      half = cnt / 2;
      mid  = lo + half;
      if (tbl_start[mid] <= q) begin
        lo  = mid + 1;
        cnt = cnt - (half + 1);
      end else begin
        cnt = half;
      end
    end
    if (lo == 0) return fwsm_pkg::ST_NO_COVER;
    diff = q - tbl_start[lo-1];
    if (tbl_dir[lo-1]) m = tbl_origin[lo-1] + diff;
    else m = tbl_origin[lo-1] - diff + {31'd0, brk};
    return fwsm_pkg::ST_OK;
  endfunction

  function automatic seg_res_t predict_segment_map(seg_req_t r);
    seg_res_t    res;
    logic [31:0] m;
    m = '0;
    case (r.command)
      fwsm_pkg::CMD_ADD: begin
        res.status = append_segment(r.start_pos, r.origin_pos, r.run_len, r.direction);
      end
      fwsm_pkg::CMD_APPEND: begin
        res.status = append_segment(walk_end(), r.origin_pos, r.run_len, r.direction);
      end
      fwsm_pkg::CMD_MAP_POS: begin
        res.status = map_query(r.query_pos, 1'b0, m);
      end
      default: begin
        res.status = map_query(r.query_pos, 1'b1, m);
      end
    endcase
    res.mapped_pos    = m;
    res.walk_length   = walk_end();
    res.segment_count = tbl_used[CNT_W-1:0];
    return res;
  endfunction

  // mostly well-formed folds, some broken ones, some noise, the rest lookups
  function automatic seg_req_t random_request();
    seg_req_t    r;
    int unsigned kind, pick, idx;
    logic [31:0] span;
    r.command    = 2'($urandom);
    r.start_pos  = $urandom;
    r.origin_pos = $urandom;
    r.run_len    = $urandom;
    r.direction  = 1'($urandom);
    r.query_pos  = $urandom;
    kind = $urandom_range(99);
    if (kind < 80) begin
      r.command = $urandom_range(1) ? fwsm_pkg::CMD_APPEND : fwsm_pkg::CMD_ADD;
      if (tbl_used != 0) begin
        if (r.command == fwsm_pkg::CMD_ADD) r.start_pos = walk_end();
        r.direction  = ~tbl_dir[tbl_used-1];
        r.origin_pos = fold_origin();
      end
      pick = $urandom_range(9);
      if (pick == 0) r.run_len = '0;
      else if (pick == 1) r.run_len = 32'hFFFF_FFFF - $urandom_range(3);
      else if (pick > 3) r.run_len = $urandom_range(1, 64);
      if (kind >= 72) begin
        case ($urandom_range(2))
          0: begin
            r.command   = fwsm_pkg::CMD_ADD;
            r.start_pos = walk_end() ^ (32'd1 << $urandom_range(31));
          end
          1: r.direction = ~r.direction;
          default: r.origin_pos = r.origin_pos ^ (32'd1 << $urandom_range(31));
        endcase
      end
    end else if (kind < 83) begin
      r.command = $urandom_range(1) ? fwsm_pkg::CMD_APPEND : fwsm_pkg::CMD_ADD;
    end else begin
      r.command = $urandom_range(1) ? fwsm_pkg::CMD_MAP_BRK : fwsm_pkg::CMD_MAP_POS;
      if (tbl_used != 0) begin
        idx  = $urandom_range(tbl_used - 1);
        span = (tbl_run[idx] == 0) ? 32'd1 : tbl_run[idx];
        case ($urandom_range(7))
          0, 1, 2: r.query_pos = tbl_start[idx] + ($urandom % span);
          3: r.query_pos = tbl_start[idx];
          4: r.query_pos = walk_end() + $urandom_range(3);
          5: r.query_pos = tbl_start[idx] - 32'd1;
          6: r.query_pos = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  function automatic vec_row_t mk_row(logic [1:0] c, logic [31:0] rp, logic [31:0] op,
                                      logic [31:0] rl, logic d, logic [31:0] q,
                                      logic t, logic [1:0] st, logic [31:0] mp,
                                      logic [31:0] wl, logic [CNT_W-1:0] sc);
    vec_row_t row;
    row.req = '{c, rp, op, rl, d, q};
    row.typed = t;
    row.res = '{st, mp, wl, sc};
    return row;
  endfunction

  task automatic send_request(seg_req_t r, logic typed, seg_res_t typed_res);
    seg_res_t res;
    while ($urandom_range(99) < idle_pct(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= r.command;
    in_start_pos  <= r.start_pos;
    in_origin_pos <= r.origin_pos;
    in_run_len    <= r.run_len;
    in_direction  <= r.direction;
    in_query_pos  <= r.query_pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_segment_map(r);
    map_results_q = {map_results_q, (typed ? typed_res : res)};
  endtask

  initial begin : stimulus
    vec_row_t    rows[$];
    int unsigned n;
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_POS, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0,
                         1'b1, fwsm_pkg::ST_NO_COVER, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_BRK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                         1'b1, fwsm_pkg::ST_NO_COVER, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_ADD, 32'd1000, 32'h100, 32'd10, 1'b1, 32'h0,
                         1'b1, fwsm_pkg::ST_OK, 32'h0, 32'd1010, CNT_W'(1))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_POS, 32'h0, 32'h0, 32'h0, 1'b0, 32'd999,
                         1'b1, fwsm_pkg::ST_NO_COVER, 32'h0, 32'd1010, CNT_W'(1))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_BRK, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0,
                         1'b1, fwsm_pkg::ST_NO_COVER, 32'h0, 32'd1010, CNT_W'(1))};
    // wrong start, same direction, bad fold
    rows = {rows, mk_row(fwsm_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h108, 32'd6, 1'b0, 32'h0,
                         1'b1, fwsm_pkg::ST_REJECT, 32'h0, 32'd1010, CNT_W'(1))};
    rows = {rows, mk_row(fwsm_pkg::CMD_ADD, 32'd1010, 32'h108, 32'd6, 1'b1, 32'h0,
                         1'b1, fwsm_pkg::ST_REJECT, 32'h0, 32'd1010, CNT_W'(1))};
    rows = {rows, mk_row(fwsm_pkg::CMD_APPEND, 32'h0, 32'hFFFF_FFFF, 32'd6, 1'b0, 32'h0,
                         1'b1, fwsm_pkg::ST_REJECT, 32'h0, 32'd1010, CNT_W'(1))};
    rows = {rows, mk_row(fwsm_pkg::CMD_ADD, 32'd1010, 32'h108, 32'd6, 1'b0, 32'h0,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_POS, 32'h0, 32'h0, 32'h0, 1'b0, 32'd1000,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_POS, 32'h0, 32'h0, 32'h0, 1'b0, 32'd1012,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_BRK, 32'h0, 32'h0, 32'h0, 1'b0, 32'd1012,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_BRK, 32'h0, 32'h0, 32'h0, 1'b0, 32'd1005,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    // full-range run wraps the walk end below its start
    rows = {rows, mk_row(fwsm_pkg::CMD_APPEND, 32'h0, 32'h104, 32'hFFFF_FFFF, 1'b1, 32'h0,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_APPEND, 32'hFFFF_FFFF, 32'h101, 32'h0, 1'b0, 32'h0,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_POS, 32'h0, 32'h0, 32'h0, 1'b0, 32'd1015,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_BRK, 32'h0, 32'h0, 32'h0, 1'b0, 32'd1016,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_POS, 32'h0, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_BRK, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_APPEND, 32'h0, 32'h103, 32'd20, 1'b1, 32'h0,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};
    rows = {rows, mk_row(fwsm_pkg::CMD_MAP_POS, 32'h0, 32'h0, 32'h0, 1'b0, 32'd1020,
                         1'b0, fwsm_pkg::ST_OK, 32'h0, 32'h0, CNT_W'(0))};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);

    n = 0;
    while (n < RAND_ITEMS) begin
      phase = (n < 2 * PHASE_ITEMS) ? int'(n / PHASE_ITEMS) : 2;
      if (n == 2 * PHASE_ITEMS) hold_request = 1'b1;
      send_request(random_request(), 1'b0, '0);
      n++;
    end
    in_valid <= 1'b0;

    while (map_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && map_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct(1'b0));
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    seg_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (map_results_q.size() == 0) begin
        $error("unexpected transfer: status %0d mapped_pos %h", out_status, out_mapped_pos);
        errors++;
      end else begin
        want = map_results_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_mapped_pos !== want.mapped_pos) begin
          $error("mapped_pos: expected %h, got %h", want.mapped_pos, out_mapped_pos);
          errors++;
        end
        if (out_walk_length !== want.walk_length) begin
          $error("walk_length: expected %h, got %h", want.walk_length, out_walk_length);
          errors++;
        end
        if (out_segment_count !== want.segment_count) begin
          $error("segment_count: expected %0d, got %0d", want.segment_count,
                 out_segment_count);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
